@@ rtl/assert_macros.svh @@
// Assertion macros included by sector_record_hit_table.sv
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Antecedent true implies consequent true in the same cycle
`define ASSERT_IMPL(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed: implication");

// Antecedent true implies consequent true in the next cycle
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed: next-cycle implication");

// Condition holds at every clock edge out of reset
`define ASSERT_ALWAYS(label, clk, rst, cond) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) \
    else $error("assertion failed: invariant");

`else

`define ASSERT_IMPL(label, clk, rst, ante, cons)
`define ASSERT_NEXT(label, clk, rst, ante, cons)
`define ASSERT_ALWAYS(label, clk, rst, cond)

`endif

`endif

@@ rtl/srht_pkg.sv @@
// Types, sizes and codes for the sector record hit table
package srht_pkg;

  // Table and block store depths
  localparam int MAX_RECORDS = 2048;
  localparam int MAX_BLOCKS  = 2048;

  // Derived internal widths
  localparam int IDX_W = $clog2(MAX_RECORDS);
  localparam int CNT_W = $clog2(MAX_RECORDS + 1);
  localparam int BLK_W = $clog2(MAX_BLOCKS);
  localparam int NB_W  = $clog2(MAX_BLOCKS + 1);

  // Field widths of one transfer
  localparam int SECTOR_W  = 48;
  localparam int SIZE_W    = 15;
  localparam int BYTES_W   = 32;
  localparam int OUT_IDX_W = 11;
  localparam int OUT_BLK_W = 11;
  localparam int OUT_CNT_W = 12;

  // Fixed shifts and limits
  localparam int SECTOR_SHIFT = 9;
  localparam int BLOCK_SHIFT  = 3;
  localparam int MIN_SIZE     = 8;

  // Slot count of one insert, and a sum wide enough for the fit check
  localparam int BLKS_W = SIZE_W - BLOCK_SHIFT;
  localparam int SUM_W  = ((NB_W > BLKS_W) ? NB_W : BLKS_W) + 1;

  typedef enum logic [1:0] {
    OP_INSERT     = 2'd0,
    OP_LOOKUP     = 2'd1,
    OP_LOAD_BEGIN = 2'd2,
    OP_LOAD_END   = 2'd3
  } opcode_t;

  typedef enum logic [2:0] {
    STAT_OK         = 3'd0,
    STAT_MISS       = 3'd1,
    STAT_TABLE_FULL = 3'd2,
    STAT_STORE_FULL = 3'd3,
    STAT_BAD_SIZE   = 3'd4
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_SCAN
  } state_t;

  typedef struct packed {
    opcode_t               opcode;
    logic [SECTOR_W-1:0]   sector;
    logic [SIZE_W-1:0]     size_sectors;
    logic [BYTES_W-1:0]    byte_count;
    logic                  target_disk;
  } in_item_t;

  typedef struct packed {
    status_t               status;
    logic [OUT_IDX_W-1:0]  record_index;
    logic [OUT_BLK_W-1:0]  first_block;
    logic [OUT_BLK_W-1:0]  last_block;
    logic [OUT_CNT_W-1:0]  records_held;
  } out_item_t;

  // One stored record
  typedef struct packed {
    logic [SECTOR_W-1:0] sector;
    logic [SIZE_W-1:0]   size;
    logic [BLK_W-1:0]    first;
    logic [BLK_W-1:0]    last;
  } rec_t;

endpackage

@@ rtl/sector_record_hit_table.sv @@
// Sector record hit table: record store, insert allocator and lookup scanner
// Insert, loading and unscanned lookup results are decided in S_EXEC and strobe on
// the registered done; a lookup scan reads one record per cycle from a registered
// read port, and ends on a hit or once all n records held have been read.
// A new start is taken only in idle, so one item is handled at a time; the receiver cannot stall.
// Synchronous reset empties the table, clears loading and partition start.
`include "assert_macros.svh"

module sector_record_hit_table
  import srht_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  output logic                busy,
  input  in_item_t            item,
  input  logic                cfg_we,
  input  logic [SECTOR_W-1:0] cfg_data,
  output logic                done,
  output out_item_t           result
);

  // Control and configuration registers
  state_t              state, state_next;
  logic [CNT_W-1:0]    record_count, count_next;
  logic [NB_W-1:0]     next_block, nb_next;
  logic                loading, loading_next;
  logic [SECTOR_W-1:0] partition_start;

  // Request, search key and scan pointers
  in_item_t            req;
  logic [SECTOR_W-1:0] key;
  logic [CNT_W-1:0]    scan_addr, scan_next;
  logic                rd_valid, rdv_next;
  logic [IDX_W-1:0]    rd_idx;
  out_item_t           res_next;
  logic                done_next;

  // Record memory
  rec_t                mem [MAX_RECORDS];
  rec_t                rd_data;
  rec_t                wr_data;
  logic                mem_we;

  // Shared datapath signals
  logic [BLKS_W-1:0]   blocks;
  logic [SUM_W-1:0]    fit_sum;
  logic [NB_W-1:0]     last_slot;
  logic                issue;
  logic                hit;
  logic                can_scan;

  assign busy = (state != S_IDLE);

  // Slot allocation for an insert
  assign blocks    = req.size_sectors[SIZE_W-1:BLOCK_SHIFT];
  assign fit_sum   = SUM_W'(next_block) + SUM_W'(blocks);
  assign last_slot = NB_W'(fit_sum - SUM_W'(1));

  // Scan issue and compare of the record read last cycle
  assign issue    = (scan_addr < record_count);
  assign hit      = rd_valid && (rd_data.sector == key) &&
                    (req.byte_count ==
                     BYTES_W'({rd_data.size, {SECTOR_SHIFT{1'b0}}}));
  assign can_scan = !loading && req.target_disk && (record_count != '0);

  assign wr_data = '{sector: req.sector,
                     size:   req.size_sectors,
                     first:  next_block[BLK_W-1:0],
                     last:   last_slot[BLK_W-1:0]};

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (start) state_next = S_EXEC;
      end
      S_EXEC: begin
        if ((req.opcode == OP_LOOKUP) && can_scan) state_next = S_SCAN;
        else state_next = S_IDLE;
      end
      S_SCAN: begin
        if (hit || !issue) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  // Datapath and result
  always_comb begin
    res_next     = result;
    done_next    = 1'b0;
    mem_we       = 1'b0;
    count_next   = record_count;
    nb_next      = next_block;
    loading_next = loading;
    scan_next    = scan_addr;
    rdv_next     = 1'b0;
    case (state)
      S_EXEC: begin
        res_next = '{status: STAT_OK, record_index: '0, first_block: '0,
                     last_block: '0, records_held: OUT_CNT_W'(record_count)};
        case (req.opcode)
          OP_INSERT: begin
            done_next = 1'b1;
            if (req.size_sectors < SIZE_W'(MIN_SIZE)) begin
              res_next.status = STAT_BAD_SIZE;
            end else if (record_count >= CNT_W'(MAX_RECORDS)) begin
              res_next.status = STAT_TABLE_FULL;
            end else if (fit_sum > SUM_W'(MAX_BLOCKS)) begin
              res_next.status = STAT_STORE_FULL;
            end else begin
              mem_we                = 1'b1;
              count_next            = record_count + CNT_W'(1);
              nb_next               = NB_W'(fit_sum);
              res_next.record_index = OUT_IDX_W'(record_count);
              res_next.first_block  = OUT_BLK_W'(next_block);
              res_next.last_block   = OUT_BLK_W'(last_slot);
              res_next.records_held = OUT_CNT_W'(count_next);
            end
          end
          OP_LOOKUP: begin
            if (can_scan) begin
              scan_next = '0;
            end else begin
              done_next       = 1'b1;
              res_next.status = STAT_MISS;
            end
          end
          OP_LOAD_BEGIN, OP_LOAD_END: begin
            done_next    = 1'b1;
            loading_next = (req.opcode == OP_LOAD_BEGIN);
          end
          default: done_next = 1'b1;
        endcase
      end
      S_SCAN: begin
        if (issue) begin
          scan_next = scan_addr + CNT_W'(1);
          rdv_next  = 1'b1;
        end
        if (hit) begin
          done_next = 1'b1;
          res_next  = '{status: STAT_OK, record_index: OUT_IDX_W'(rd_idx),
                        first_block: OUT_BLK_W'(rd_data.first),
                        last_block: OUT_BLK_W'(rd_data.last),
                        records_held: OUT_CNT_W'(record_count)};
        end else if (!issue) begin
          done_next = 1'b1;
          res_next  = '{status: STAT_MISS, record_index: '0, first_block: '0,
                        last_block: '0, records_held: OUT_CNT_W'(record_count)};
        end
      end
      default: ;
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= S_IDLE;
      record_count    <= '0;
      next_block      <= '0;
      loading         <= 1'b0;
      partition_start <= '0;
      rd_valid        <= 1'b0;
      done            <= 1'b0;
    end else begin
      state        <= state_next;
      record_count <= count_next;
      next_block   <= nb_next;
      loading      <= loading_next;
      rd_valid     <= rdv_next;
      done         <= done_next;
      if (cfg_we) partition_start <= cfg_data;
    end
  end

  // Payload registers: hold the request, form the search key, track the scan
  always_ff @(posedge clk) begin
    if ((state == S_IDLE) && start) req <= item;
    if (state == S_EXEC) key <= req.sector + partition_start;
    scan_addr <= scan_next;
    if (issue) rd_idx <= scan_addr[IDX_W-1:0];
    result <= res_next;
  end

  // Record memory: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (mem_we) mem[record_count[IDX_W-1:0]] <= wr_data;
  end

  always_ff @(posedge clk) begin
    rd_data <= mem[scan_addr[IDX_W-1:0]];
  end

  // Checks
  `ASSERT_NEXT(a_start_busy, clk, rst, start && !busy, busy)
  `ASSERT_IMPL(a_done_after_busy, clk, rst, done, $past(busy))
  `ASSERT_ALWAYS(a_count_bound, clk, rst, record_count <= CNT_W'(MAX_RECORDS))
  `ASSERT_ALWAYS(a_block_bound, clk, rst, next_block <= NB_W'(MAX_BLOCKS))

endmodule
